// File: rtl/eatu_pkg.sv
// eatu_pkg: shared types and codes of the expiring access table
`timescale 1ns / 1ps
`default_nettype none

package eatu_pkg;

    // field widths
    localparam int KEY_W   = 32;
    localparam int COLOR_W = 2;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 7;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd1;
    localparam logic [OP_W-1:0] OP_REAP  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_ADDED   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd3;

    // one table entry as held in memory
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COLOR_W-1:0] color;
        logic [TIME_W-1:0]  expiry;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] count;
    } t_result;

    // scan engine states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// File: rtl/expiring_ip_access_table_unit.sv
// Flow: an input beat is taken only while the engine is idle; the engine then scans the table,
// and the result goes through the result register to the result stream.
// Each item is finished before the next is taken; every operation walks all entries
// through the single read port of the entry memory, one entry a cycle; a held result
// beat (tready low) delays the next item, since the engine waits for the result register.
// Reset: synchronous, active low; a clearing pass over every entry then zeroes
`timescale 1ns / 1ps
`default_nettype none

// the entry memory with tready held low; default colour resets to 0
module expiring_ip_access_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [87:0]  i_s_axis_tdata,   // key_address[31:0], entry_color[33:32],
                                          // time_value[81:34], zero fill
    input  wire [1:0]   i_s_axis_tuser,   // operation[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // result_color[1:0], reaped_count[8:2],
                                          // zero fill
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire [1:0]   i_cfg_wr_data     // default_color[1:0]
);
    import eatu_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COLOR_W-1:0] r_default_color;
    logic               r_out_valid;
    t_result            r_out;

    logic               start;
    logic               out_free;
    logic               eng_ready;
    logic               res_valid;
    t_result            res;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    t_entry             mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    t_entry             mem_rdata;

    assign o_s_axis_tready = eng_ready;
    assign start           = i_s_axis_tvalid && eng_ready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // default colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color <= '0;
        end else if (i_cfg_wr_en) begin
            r_default_color <= i_cfg_wr_data;
        end
    end

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {7'b0, r_out.count, r_out.color};

    eatu_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_op            (i_s_axis_tuser),
        .i_key           (i_s_axis_tdata[31:0]),
        .i_color         (i_s_axis_tdata[33:32]),
        .i_time          (i_s_axis_tdata[81:34]),
        .i_default_color (r_default_color),
        .i_out_free      (out_free),
        .o_ready         (eng_ready),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .i_mem_rdata     (mem_rdata)
    );

    eatu_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/eatu_mem.sv
// eatu_mem: entry memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module eatu_mem #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = 6
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  eatu_pkg::t_entry    i_wdata,
    input  wire                 i_re,
    input  wire [AW-1:0]        i_raddr,
    output eatu_pkg::t_entry    o_rdata
);
    import eatu_pkg::*;

    t_entry r_mem [0:TABLE_DEPTH-1];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/eatu_ctrl.sv
// eatu_ctrl: scan engine that walks the entry memory for set, check and reap
`timescale 1ns / 1ps
`default_nettype none

module eatu_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [eatu_pkg::OP_W-1:0]     i_op,
    input  wire [eatu_pkg::KEY_W-1:0]    i_key,
    input  wire [eatu_pkg::COLOR_W-1:0]  i_color,
    input  wire [eatu_pkg::TIME_W-1:0]   i_time,
    input  wire [eatu_pkg::COLOR_W-1:0]  i_default_color,
    input  wire                          i_out_free,
    output logic                         o_ready,
    output logic                         o_res_valid,
    output eatu_pkg::t_result            o_res,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output eatu_pkg::t_entry             o_mem_wdata,
    output logic                         o_mem_re,
    output logic [AW-1:0]                o_mem_raddr,
    input  eatu_pkg::t_entry             i_mem_rdata
);
    import eatu_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

    t_state r_state, n_state;

    // address counter, shared by the clearing pass and the scan
    logic [CW-1:0]      r_idx;
    logic               r_pend;
    logic [AW-1:0]      r_pidx;

    // latched item
    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [COLOR_W-1:0] r_color;
    logic [TIME_W-1:0]  r_time;

    // scan findings
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic [COLOR_W-1:0] r_hit_color;
    logic               r_hit_live;
    logic               r_free;
    logic [AW-1:0]      r_free_idx;
    logic [CW-1:0]      r_cnt;

    logic               ent_match;
    logic               ent_free;
    logic               ent_expired;
    logic [CW+COUNT_W-1:0] cnt_ext;

    // per-entry tests on the word just read
    assign ent_match   = r_pend && i_mem_rdata.valid && (i_mem_rdata.key == r_key);
    assign ent_free    = r_pend && !i_mem_rdata.valid && !r_free;
    assign ent_expired = r_pend && (r_op == OP_REAP) && i_mem_rdata.valid
                         && (i_mem_rdata.expiry <= r_time);
    assign cnt_ext     = {{COUNT_W{1'b0}}, r_cnt};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_C) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_idx == DEPTH_C) && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs: memory ports and result
    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_SCAN: begin
                o_mem_re = (r_idx < DEPTH_C);
                // free an expired entry in place
                o_mem_we          = ent_expired;
                o_mem_waddr       = r_pidx;
                o_mem_wdata       = i_mem_rdata;
                o_mem_wdata.valid = 1'b0;
            end
            S_FIN: begin
                o_res_valid        = i_out_free;
                o_res.status       = STAT_DONE;
                o_mem_wdata.valid  = 1'b1;
                o_mem_wdata.key    = r_key;
                o_mem_wdata.color  = r_color;
                o_mem_wdata.expiry = r_time;
                priority if (r_op == OP_SET) begin
                    if (r_hit) begin
                        o_res.status = STAT_UPDATED;
                        o_mem_we     = i_out_free;
                        o_mem_waddr  = r_hit_idx;
                    end else if (r_free) begin
                        o_res.status = STAT_ADDED;
                        o_mem_we     = i_out_free;
                        o_mem_waddr  = r_free_idx;
                    end else begin
                        o_res.status = STAT_FULL;
                    end
                end else if (r_op == OP_CHECK) begin
                    o_res.color = (r_hit && r_hit_live) ? r_hit_color : i_default_color;
                end else if (r_op == OP_REAP) begin
                    o_res.count = cnt_ext[COUNT_W-1:0];
                end else begin
                    o_res.status = STAT_DONE;
                end
            end
            default: o_ready = 1'b0;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                end
                S_IDLE: begin
                    r_idx  <= '0;
                    r_pend <= 1'b0;
                end
                S_SCAN: begin
                    r_pend <= (r_idx < DEPTH_C);
                    if (r_idx < DEPTH_C) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    r_pend <= 1'b0;
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    // item capture and scan findings
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_color <= i_color;
            r_time  <= i_time;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_cnt   <= '0;
        end
        if (r_state == S_SCAN) begin
            r_pidx <= r_idx[AW-1:0];
            if (ent_match) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_pidx;
                r_hit_color <= i_mem_rdata.color;
                r_hit_live  <= (i_mem_rdata.expiry > r_time);
            end
            if (ent_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (ent_expired) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
